// File: design/pip_pkg.sv
package pip_pkg;

    // default coordinate width, signed fixed point (Q16.8 at 24 bits)
    localparam int COORD_BITS_DEF = 24;

    // legal range of the coordinate width
    localparam int COORD_BITS_MIN = 8;
    localparam int COORD_BITS_MAX = 32;

endpackage

// File: design/pip_in_if.sv
interface pip_in_if #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic                         last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
        output ready
    );
endinterface

// File: design/pip_out_if.sv
interface pip_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (
        output valid, inside_res,
        input  ready
    );

    modport sink (
        input  valid, inside_res,
        output ready
    );
endinterface

// File: design/point_in_polygon_even_odd_unit.sv
// Even-odd point-in-polygon test with a ray cast along +X. Vertices stream in one
// word per cycle; the first word of a polygon also carries the query point, which
// is held until the polygon closes, and the word marked last_vertex closes the
// polygon and yields one result word (inside_res). Polygons with fewer than three
// vertices give 0. Throughput is one vertex per cycle unless the output stalls; the
// result of a closing vertex is held in the stage a, stage b and output registers
// in turn. The three stages are vertex bookkeeping, the edge test (two exact signed
// cross products per edge for the new edge and the closing edge, compared without
// division), and the parity update feeding the output register. Stages advance
// independently, so empty stages still take input while a result waits.
module point_in_polygon_even_odd_unit #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pip_in_if.sink      i_vtx,
    pip_out_if.source   o_res
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DW-1:0]         t_diff;
    typedef logic signed [PW-1:0]         t_prod;

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_FULL = 2'd3;

    // edge from b to a toggles parity if it straddles qy and q lies left of it
    function automatic logic edge_toggles(input t_coord ax, input t_coord ay,
                                          input t_coord bx, input t_coord by,
                                          input t_coord qx, input t_coord qy);
        t_diff d;
        t_diff dqx;
        t_diff dqy;
        t_diff dbx;
        t_prod lhs;
        t_prod rhs;
        logic  straddle;
        begin
            straddle = (ay > qy) != (by > qy);
            d        = DW'(by) - DW'(ay);
            dqx      = DW'(qx) - DW'(ax);
            dqy      = DW'(qy) - DW'(ay);
            dbx      = DW'(bx) - DW'(ax);
            lhs      = PW'(dqx) * PW'(d);
            rhs      = PW'(dqy) * PW'(dbx);
            if (!straddle) begin
                edge_toggles = 1'b0;
            end else if (d > 0) begin
                edge_toggles = lhs < rhs;
            end else begin
                edge_toggles = rhs < lhs;
            end
        end
    endfunction

    // polygon bookkeeping state
    t_coord     r_first_x, r_first_y;
    t_coord     r_prev_x, r_prev_y;
    t_coord     r_held_qx, r_held_qy;
    logic [1:0] r_seen;

    // stage a: vertex with its edge endpoints and query
    logic   r_a_valid, r_a_first, r_a_last, r_a_close;
    t_coord r_a_vx, r_a_vy, r_a_px, r_a_py, r_a_fx, r_a_fy, r_a_qx, r_a_qy;

    // stage b: edge toggles
    logic r_b_valid, r_b_first, r_b_last, r_b_close, r_b_t_edge, r_b_t_close;

    // stage c: parity and output register
    logic r_parity;
    logic r_out_valid;
    logic r_out_inside;

    // stage enables, each stage moves when its successor has room
    logic en_c, en_b, en_a;
    assign en_c = !r_out_valid || o_res.ready;
    assign en_b = !r_b_valid || en_c;
    assign en_a = !r_a_valid || en_b;

    assign i_vtx.ready = en_a;

    logic accept;
    assign accept = i_vtx.valid && en_a;

    // bookkeeping for the incoming word
    logic       is_first;
    logic [1:0] n_seen_after;
    t_coord     n_qx, n_qy;
    assign is_first = r_seen == SEEN_NONE;
    assign n_qx     = is_first ? i_vtx.query_x : r_held_qx;
    assign n_qy     = is_first ? i_vtx.query_y : r_held_qy;

    always_comb begin
        if (is_first) begin
            n_seen_after = SEEN_ONE;
        end else if (r_seen == SEEN_FULL) begin
            n_seen_after = SEEN_FULL;
        end else begin
            n_seen_after = r_seen + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= SEEN_NONE;
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_held_qx <= '0;
            r_held_qy <= '0;
        end else if (accept) begin
            r_seen   <= i_vtx.last_vertex ? SEEN_NONE : n_seen_after;
            r_prev_x <= i_vtx.vertex_x;
            r_prev_y <= i_vtx.vertex_y;
            if (is_first) begin
                r_first_x <= i_vtx.vertex_x;
                r_first_y <= i_vtx.vertex_y;
                r_held_qx <= i_vtx.query_x;
                r_held_qy <= i_vtx.query_y;
            end
        end
    end

    // stage a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_vtx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_first <= is_first;
            r_a_last  <= i_vtx.last_vertex;
            r_a_close <= i_vtx.last_vertex && (n_seen_after == SEEN_FULL);
            r_a_vx    <= i_vtx.vertex_x;
            r_a_vy    <= i_vtx.vertex_y;
            r_a_px    <= r_prev_x;
            r_a_py    <= r_prev_y;
            r_a_fx    <= is_first ? i_vtx.vertex_x : r_first_x;
            r_a_fy    <= is_first ? i_vtx.vertex_y : r_first_y;
            r_a_qx    <= n_qx;
            r_a_qy    <= n_qy;
        end
    end

    // edge tests: new edge prev -> cur, closing edge cur -> first
    logic t_edge, t_close;
    assign t_edge  = edge_toggles(r_a_vx, r_a_vy, r_a_px, r_a_py, r_a_qx, r_a_qy);
    assign t_close = edge_toggles(r_a_fx, r_a_fy, r_a_vx, r_a_vy, r_a_qx, r_a_qy);

    // stage b register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && r_a_valid) begin
            r_b_first   <= r_a_first;
            r_b_last    <= r_a_last;
            r_b_close   <= r_a_close;
            r_b_t_edge  <= !r_a_first && t_edge;
            r_b_t_close <= r_a_close && t_close;
        end
    end

    // parity update
    logic n_parity;
    assign n_parity = (r_b_first ? 1'b0 : r_parity) ^ r_b_t_edge ^ r_b_t_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (en_c && r_b_valid) begin
            r_parity <= n_parity;
        end
    end

    // output register, loaded only by a closing vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_c) begin
            r_out_valid <= r_b_valid && r_b_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_valid && r_b_last) begin
            r_out_inside <= r_b_close && n_parity;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.inside_res = r_out_inside;

endmodule
